// ----- design/lsdd_pkg.sv -----
// Shared constants and types for the limb stream divider.
// Used by the divisor register file, the division core and the top level.
package lsdd_pkg;

   localparam int FIELD_BITS        = 64;
   localparam int LIMB_BITS_DEFAULT = 64;
   localparam int SHIFT_BITS        = 6;
   localparam int CSR_IDX_BITS      = 2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_DIVISOR_LOW  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DIVISOR_HIGH = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SHIFT_AMOUNT = 2'd2;

   localparam logic [FIELD_BITS-1:0] DIVISOR_HIGH_RESET = 64'h8000_0000_0000_0000;

   // Commands from the top level to the division core
   typedef struct packed {
      logic load;      // first limb of a dividend: load it as the partial remainder
      logic start;     // start the bit-serial division of the limb
      logic zero_rem;  // start from a zero partial remainder
   } lsdd_cmd_type;

endpackage

// ----- design/lsdd_divisor.sv -----
// Divisor registers: normalized divisor pair and shift count, written through the csr port.
// Produces the true divisor (normalized value shifted back down). Depends on lsdd_pkg.
module lsdd_divisor
   import lsdd_pkg::*;
#(
   parameter int LIMB_BITS = LIMB_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wen,
   input  logic [CSR_IDX_BITS-1:0]   csr_index,
   input  logic [FIELD_BITS-1:0]     csr_wdata,
   output logic [2*LIMB_BITS-1:0]    divisor
);

   localparam logic [SHIFT_BITS:0] LIMB_W = (SHIFT_BITS + 1)'(LIMB_BITS);

   logic [FIELD_BITS-1:0] div_low_ff;
   logic [FIELD_BITS-1:0] div_high_ff;
   logic [SHIFT_BITS-1:0] shift_ff;
   logic [SHIFT_BITS-1:0] shift_mod;
   logic [2*LIMB_BITS-1:0] norm;

   always_ff @(posedge clock) begin
      if (reset) begin
         div_low_ff  <= '0;
         div_high_ff <= DIVISOR_HIGH_RESET;
         shift_ff    <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_DIVISOR_LOW:  div_low_ff  <= csr_wdata;
            CSR_DIVISOR_HIGH: div_high_ff <= csr_wdata;
            CSR_SHIFT_AMOUNT: shift_ff    <= csr_wdata[SHIFT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Reduce the shift count modulo the limb width (up to eight narrow conditional subtracts)
   always_comb begin
      shift_mod = shift_ff;
      for (int i = 0; i < 8; i++) begin
         if ({1'b0, shift_mod} >= LIMB_W) begin
            shift_mod = shift_mod - LIMB_W[SHIFT_BITS-1:0];
         end
      end
   end

   assign norm    = {div_high_ff[LIMB_BITS-1:0], div_low_ff[LIMB_BITS-1:0]};
   assign divisor = norm >> shift_mod;

endmodule

// ----- design/lsdd_core.sv -----
// Radix-2 restoring division core: the limb shifts out one bit per cycle into the
// partial remainder, and one quotient bit shifts in per cycle. Depends on lsdd_pkg.
module lsdd_core
   import lsdd_pkg::*;
#(
   parameter int LIMB_BITS = LIMB_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lsdd_cmd_type              cmd,
   input  logic [LIMB_BITS-1:0]      limb,
   input  logic [2*LIMB_BITS-1:0]    divisor,
   output logic                      done,
   output logic [LIMB_BITS-1:0]      quotient,
   output logic [2*LIMB_BITS-1:0]    remainder
);

   localparam int CNT_BITS = $clog2(LIMB_BITS);

   logic                   busy_ff;
   logic                   done_ff;
   logic [CNT_BITS-1:0]    count_ff;
   logic [LIMB_BITS-1:0]   x_ff;
   logic [LIMB_BITS-1:0]   q_ff;
   logic [2*LIMB_BITS-1:0] r_ff;
   logic [2*LIMB_BITS-1:0] d_ff;

   logic                   carry;
   logic [2*LIMB_BITS-1:0] shifted;
   logic [2*LIMB_BITS-1:0] diff;
   logic                   take;
   logic [2*LIMB_BITS-1:0] r_in;

   assign carry   = r_ff[2*LIMB_BITS-1];
   assign shifted = {r_ff[2*LIMB_BITS-2:0], x_ff[LIMB_BITS-1]};
   assign diff    = shifted - d_ff;
   // A bit carried out of the remainder means it surely exceeds the divisor
   assign take    = carry | (shifted >= d_ff);
   assign r_in    = take ? diff : shifted;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff  <= 1'b1;
            count_ff <= CNT_BITS'(LIMB_BITS - 1);
         end else if (busy_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         r_ff <= (2*LIMB_BITS)'(limb);
      end else if (cmd.start) begin
         r_ff <= cmd.zero_rem ? '0 : r_ff;
         x_ff <= limb;
         d_ff <= divisor;
      end else if (busy_ff) begin
         r_ff <= r_in;
         x_ff <= x_ff << 1;
         q_ff <= {q_ff[LIMB_BITS-2:0], take};
      end
   end

   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = r_ff;

endmodule

// ----- design/limb_stream_divide_by_double_word_top.sv -----
// Divides a dividend streamed as LIMB_BITS-bit limbs, most significant first, by a
// two-limb divisor set through the csr port. The first limb of a dividend is taken
// without a division and gives no response; every later limb runs through the radix-2
// subtract loop in the core, which retires one quotient bit per cycle, and then gets
// a registered response. A new request is taken once the previous quotient limb is
// in the output register, even while that response waits. Each response carries one
// quotient limb; the one marked by tlast also carries the final remainder. Limbs and
// divisor use only their low LIMB_BITS bits.
// Depends on lsdd_pkg, lsdd_divisor and lsdd_core.
module limb_stream_divide_by_double_word_top
   import lsdd_pkg::*;
#(
   parameter int LIMB_BITS = LIMB_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [FIELD_BITS-1:0]     req_tdata,   // limb
   input  logic                      req_tlast,   // last_limb
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [3*FIELD_BITS-1:0]   rsp_tdata,   // quotient_limb, rem_low, rem_high
   output logic                      rsp_tlast,   // is_last
   input  logic                      csr_wen,
   input  logic [CSR_IDX_BITS-1:0]   csr_index,
   input  logic [FIELD_BITS-1:0]     csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BUSY,
      ST_HOLD
   } state_type;

   state_type               state_ff;
   logic                    seen_first_ff;
   logic                    last_ff;
   logic                    rsp_tvalid_ff;
   logic                    rsp_tlast_ff;
   logic [3*FIELD_BITS-1:0] rsp_tdata_ff;

   logic                    accept;
   logic                    out_free;
   logic                    done;
   lsdd_cmd_type            cmd;
   logic [2*LIMB_BITS-1:0]  divisor;
   logic [LIMB_BITS-1:0]    quotient;
   logic [2*LIMB_BITS-1:0]  remainder;
   logic [3*FIELD_BITS-1:0] result;

   lsdd_divisor #(.LIMB_BITS(LIMB_BITS)) u_divisor (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .divisor   (divisor)
   );

   lsdd_core #(.LIMB_BITS(LIMB_BITS)) u_core (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .limb      (req_tdata[LIMB_BITS-1:0]),
      .divisor   (divisor),
      .done      (done),
      .quotient  (quotient),
      .remainder (remainder)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign out_free   = ~rsp_tvalid_ff | rsp_tready;

   // A lone last limb behaves as if a zero limb came first
   always_comb begin
      cmd.load     = accept & ~seen_first_ff & ~req_tlast;
      cmd.start    = accept & (seen_first_ff | req_tlast);
      cmd.zero_rem = ~seen_first_ff;
   end

   // Remainder fields stay zero except on the last quotient limb
   always_comb begin
      result = '0;
      result[FIELD_BITS-1:0] = FIELD_BITS'(quotient);
      if (last_ff) begin
         result[2*FIELD_BITS-1:FIELD_BITS]   = FIELD_BITS'(remainder[LIMB_BITS-1:0]);
         result[3*FIELD_BITS-1:2*FIELD_BITS] = FIELD_BITS'(remainder[2*LIMB_BITS-1:LIMB_BITS]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         seen_first_ff <= 1'b0;
         last_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         rsp_tlast_ff  <= 1'b0;
         rsp_tdata_ff  <= '0;
      end else begin
         if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (cmd.load) begin
                  seen_first_ff <= 1'b1;
               end else if (cmd.start) begin
                  seen_first_ff <= ~req_tlast;
                  last_ff       <= req_tlast;
                  state_ff      <= ST_BUSY;
               end
            end
            ST_BUSY: begin
               if (done) begin
                  if (out_free) begin
                     rsp_tvalid_ff <= 1'b1;
                     rsp_tdata_ff  <= result;
                     rsp_tlast_ff  <= last_ff;
                     state_ff      <= ST_IDLE;
                  end else begin
                     state_ff <= ST_HOLD;
                  end
               end
            end
            ST_HOLD: begin
               // hold the finished quotient until the output register frees up
               if (out_free) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= result;
                  rsp_tlast_ff  <= last_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

// ----- design/lsdd_checker.sv -----
// Port-level checks for the limb stream divider, bound to the top level.
// Depends on lsdd_pkg for field widths.
module lsdd_checker
   import lsdd_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_tvalid,
   input logic                    req_tready,
   input logic                    req_tlast,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic [3*FIELD_BITS-1:0] rsp_tdata,
   input logic                    rsp_tlast
);

   // a stalled response stays valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // a stalled response holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response payload changed while stalled");

   // remainder fields are zero except on the last quotient limb
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[3*FIELD_BITS-1:FIELD_BITS] == '0)
      else $error("remainder shown on a non-last response");

   // a last limb always starts a division, so no request is taken right after it
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("request taken while a division runs");

endmodule

bind limb_stream_divide_by_double_word_top lsdd_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
